FILE: src/gts_pkg.sv
package gts_pkg;

    // Default and upper limit of the number of list entries.
    localparam int C_MAX_TOP       = 8;
    localparam int C_MAX_TOP_LIMIT = 16;
    localparam int C_MAX_DENSITY   = 256;

    // Counts of list entries (up to the largest supported list) travel in this width.
    localparam int C_CNT_W = $clog2(C_MAX_TOP_LIMIT + 1);

    localparam int C_QUEUE_DEPTH = 4;

    localparam logic [31:0] C_SCORE_MIN = 32'h8000_0000;

    localparam int C_CFG_IDX_W  = 2;
    localparam int C_CFG_DATA_W = 9;

    localparam logic [C_CFG_IDX_W-1:0] C_REG_TOP_COUNT     = 2'd0;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_DENSITY_COUNT = 2'd1;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_PRODUCT_SHIFT = 2'd2;

    localparam logic [3:0] C_RST_TOP_COUNT     = 4'd4;
    localparam logic [8:0] C_RST_DENSITY_COUNT = 9'd256;
    localparam logic [4:0] C_RST_PRODUCT_SHIFT = 5'd0;

    typedef struct packed {
        logic [3:0] top_count;
        logic [8:0] density_count;
        logic [4:0] product_shift;
    } t_cfg;

    // Per-beat information that rides along the scoring pipeline.
    typedef struct packed {
        logic [31:0]        log_norm;
        logic [7:0]         density_id;
        logic               first_dim;
        logic               last_dim;
        logic               last_density;
        logic [4:0]         shift;
        logic [C_CNT_W-1:0] n_eff;
        logic [C_CNT_W-1:0] emit_cnt;
        logic               all_path;
        logic               slot_ok;
    } t_side;

    // Work handed from the scoring front to the list back end.
    typedef struct packed {
        logic [31:0]        score;
        logic [7:0]         density_id;
        logic               ins_top;
        logic               ins_slot;
        logic               frame_end;
        logic [C_CNT_W-1:0] n_eff;
        logic [C_CNT_W-1:0] emit_cnt;
        logic               all_path;
    } t_event;

endpackage

FILE: src/gts_front.sv
module gts_front #(
    parameter int MAX_TOP = gts_pkg::C_MAX_TOP
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gts_pkg::t_cfg       i_cfg,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic signed [15:0]  i_obs_value,
    input  logic signed [15:0]  i_mean_value,
    input  logic [15:0]         i_precision,
    input  logic signed [31:0]  i_log_norm,
    input  logic [7:0]          i_density_id,
    input  logic                i_first_dim,
    input  logic                i_last_dim,
    input  logic                i_last_density,
    input  logic                i_q_full,
    output logic                o_ev_push,
    output gts_pkg::t_event     o_ev
);
    import gts_pkg::*;

    logic               advance;
    logic [31:0]        n_w;
    logic [31:0]        nd_w;
    logic               all_path;
    t_side              in_side;
    logic signed [16:0] in_diff;

    logic               r_a_valid;
    logic signed [16:0] r_a_diff;
    logic [15:0]        r_a_prec;
    t_side              r_a_side;

    logic               r_b_valid;
    logic [31:0]        r_b_sq;
    logic [15:0]        r_b_prec;
    t_side              r_b_side;

    logic               r_c_valid;
    logic [47:0]        r_c_prod;
    t_side              r_c_side;

    logic               r_d_valid;
    logic [47:0]        r_d_term;
    t_side              r_d_side;

    logic signed [33:0] sq_full;
    logic [31:0]        base;
    logic [49:0]        acc_wide;
    logic               sat;
    logic [31:0]        r_acc;
    logic [31:0]        n_acc;

    // The whole pipeline moves together; it freezes only while the queue is full.
    assign advance    = !i_q_full;
    assign o_in_stall = i_q_full;

    always_comb begin
        n_w = (i_cfg.top_count == '0) ? 32'd1 : 32'(i_cfg.top_count);
        if (n_w > 32'(MAX_TOP)) begin
            n_w = 32'(MAX_TOP);
        end
        nd_w = (i_cfg.density_count == '0) ? 32'd1 : 32'(i_cfg.density_count);
        if (nd_w > 32'(C_MAX_DENSITY)) begin
            nd_w = 32'(C_MAX_DENSITY);
        end
        all_path = (n_w >= nd_w);

        in_side.log_norm     = i_log_norm;
        in_side.density_id   = i_density_id;
        in_side.first_dim    = i_first_dim;
        in_side.last_dim     = i_last_dim;
        in_side.last_density = i_last_density;
        in_side.shift        = i_cfg.product_shift;
        in_side.n_eff        = C_CNT_W'(n_w);
        // On the all-densities path the density count never exceeds the list size.
        in_side.emit_cnt     = all_path ? C_CNT_W'(nd_w) : C_CNT_W'(n_w);
        in_side.all_path     = all_path;
        in_side.slot_ok      = all_path && (32'(i_density_id) < nd_w);
    end

    assign in_diff = {i_obs_value[15], i_obs_value} - {i_mean_value[15], i_mean_value};
    assign sq_full = r_a_diff * r_a_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (advance) begin
            r_a_valid <= i_in_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_diff <= in_diff;
            r_a_prec <= i_precision;
            r_a_side <= in_side;

            // The square of a 17-bit difference always fits in 32 unsigned bits.
            r_b_sq   <= sq_full[31:0];
            r_b_prec <= r_a_prec;
            r_b_side <= r_a_side;

            r_c_prod <= 48'(r_b_sq) * 48'(r_b_prec);
            r_c_side <= r_b_side;

            r_d_term <= r_c_prod >> r_c_side.shift;
            r_d_side <= r_c_side;
        end
    end

    // The term is never negative, so only the low end can overflow.
    always_comb begin
        base     = r_d_side.first_dim ? r_d_side.log_norm : r_acc;
        acc_wide = {{18{base[31]}}, base} - {2'b00, r_d_term};
        sat      = acc_wide[49] && !(&acc_wide[48:31]);
        n_acc    = sat ? C_SCORE_MIN : acc_wide[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (advance && r_d_valid) begin
            r_acc <= n_acc;
        end
    end

    assign o_ev_push = advance && r_d_valid && (r_d_side.last_dim || r_d_side.last_density);

    always_comb begin
        o_ev.score      = n_acc;
        o_ev.density_id = r_d_side.density_id;
        o_ev.ins_top    = r_d_side.last_dim && !r_d_side.all_path;
        o_ev.ins_slot   = r_d_side.last_dim && r_d_side.slot_ok;
        o_ev.frame_end  = r_d_side.last_density;
        o_ev.n_eff      = r_d_side.n_eff;
        o_ev.emit_cnt   = r_d_side.emit_cnt;
        o_ev.all_path   = r_d_side.all_path;
    end

endmodule

FILE: src/gts_queue.sv
module gts_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gts_pkg::t_event i_ev,
    output logic            o_full,
    output logic            o_empty,
    input  logic            i_pop,
    output gts_pkg::t_event o_head
);
    import gts_pkg::*;

    localparam int PTR_W = (C_QUEUE_DEPTH > 1) ? $clog2(C_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(C_QUEUE_DEPTH + 1);

    t_event             r_mem [C_QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [CNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == CNT_W'(C_QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(C_QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(C_QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: src/gts_back.sv
module gts_back #(
    parameter int MAX_TOP = gts_pkg::C_MAX_TOP
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  gts_pkg::t_event i_ev,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [31:0]     o_score,
    output logic [7:0]      o_best_id,
    output logic            o_last_result
);
    import gts_pkg::*;

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_EMIT = 1'b1;

    logic [0:0]         r_state;
    logic [C_CNT_W-1:0] r_idx;
    logic [C_CNT_W-1:0] r_cnt;
    logic               r_all;
    logic [31:0]        r_top_score [MAX_TOP];
    logic [7:0]         r_top_id    [MAX_TOP];
    logic [31:0]        n_top_score [MAX_TOP];
    logic [7:0]         n_top_id    [MAX_TOP];

    logic               r_out_valid;
    logic [31:0]        r_out_score;
    logic [7:0]         r_out_id;
    logic               r_out_last;

    logic [MAX_TOP-1:0] ge;
    logic [MAX_TOP-1:0] ahead;
    logic               load;
    logic               last_beat;
    logic [C_CNT_W-1:0] idx_next;
    logic [31:0]        sel_score;
    logic [7:0]         sel_id;

    assign o_pop     = (r_state == S_IDLE) && !i_q_empty;
    assign load      = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);
    assign idx_next  = r_idx + 1'b1;
    assign last_beat = (idx_next == r_cnt);

    // Insertion position: the first live entry that the new score ties or beats.
    always_comb begin
        for (int j = 0; j < MAX_TOP; j++) begin
            ge[j] = (C_CNT_W'(j) < i_ev.n_eff) &&
                    ($signed(i_ev.score) >= $signed(r_top_score[j]));
        end
        ahead[0] = 1'b0;
        for (int j = 1; j < MAX_TOP; j++) begin
            ahead[j] = ahead[j-1] || ge[j-1];
        end

        for (int j = 0; j < MAX_TOP; j++) begin
            n_top_score[j] = r_top_score[j];
            n_top_id[j]    = r_top_id[j];
            if (o_pop && i_ev.ins_top && (C_CNT_W'(j) < i_ev.n_eff)) begin
                if (ahead[j]) begin
                    n_top_score[j] = r_top_score[(j > 0) ? j - 1 : 0];
                    n_top_id[j]    = r_top_id[(j > 0) ? j - 1 : 0];
                end else if (ge[j]) begin
                    n_top_score[j] = i_ev.score;
                    n_top_id[j]    = i_ev.density_id;
                end
            end
            if (o_pop && i_ev.ins_slot && (i_ev.density_id == 8'(j))) begin
                n_top_score[j] = i_ev.score;
                n_top_id[j]    = i_ev.density_id;
            end
            if (load && last_beat) begin
                n_top_score[j] = C_SCORE_MIN;
                n_top_id[j]    = '0;
            end
        end
    end

    always_comb begin
        sel_score = C_SCORE_MIN;
        sel_id    = '0;
        for (int j = 0; j < MAX_TOP; j++) begin
            if (r_idx == C_CNT_W'(j)) begin
                sel_score = r_top_score[j];
                sel_id    = r_top_id[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_TOP; j++) begin
                r_top_score[j] <= C_SCORE_MIN;
                r_top_id[j]    <= '0;
            end
        end else begin
            for (int j = 0; j < MAX_TOP; j++) begin
                r_top_score[j] <= n_top_score[j];
                r_top_id[j]    <= n_top_id[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_all       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_pop && i_ev.frame_end) begin
                        r_state <= S_EMIT;
                        r_idx   <= '0;
                        r_cnt   <= i_ev.emit_cnt;
                        r_all   <= i_ev.all_path;
                    end
                end
                S_EMIT: begin
                    if (load) begin
                        r_idx <= idx_next;
                        if (last_beat) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_score <= sel_score;
            r_out_id    <= r_all ? 8'(r_idx) : sel_id;
            r_out_last  <= last_beat;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_score       = r_out_score;
    assign o_best_id     = r_out_id;
    assign o_last_result = r_out_last;

endmodule

FILE: src/gaussian_topn_scorer.sv
// A density's score passes the scoring stages and the event queue before it reaches the list;
// a frame's results are emitted once its frame-end event has been taken from the queue.
// Throughput: one input beat per cycle through the four-stage scoring pipeline while the
// queue has room; a frame end holds the list unit while it emits the frame's results, and
// input stalls once its 4-entry queue fills.
// Reset is synchronous and active low: it empties pipeline and queue, zeroes the accumulator,
// clears the list and loads the register defaults (top 4, densities 256, shift 0).
module gaussian_topn_scorer #(
    parameter int MAX_TOP = gts_pkg::C_MAX_TOP
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gts_pkg::C_CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gts_pkg::C_CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [15:0]                  i_obs_value,
    input  logic signed [15:0]                  i_mean_value,
    input  logic [15:0]                         i_precision,
    input  logic signed [31:0]                  i_log_norm,
    input  logic [7:0]                          i_density_id,
    input  logic                                i_first_dim,
    input  logic                                i_last_dim,
    input  logic                                i_last_density,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [31:0]                  o_score,
    output logic [7:0]                          o_best_id,
    output logic                                o_last_result
);
    import gts_pkg::*;

    t_cfg        r_cfg;
    t_event      push_ev;
    t_event      head_ev;
    logic        ev_push;
    logic        ev_pop;
    logic        q_full;
    logic        q_empty;
    logic [31:0] score_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.top_count     <= C_RST_TOP_COUNT;
            r_cfg.density_count <= C_RST_DENSITY_COUNT;
            r_cfg.product_shift <= C_RST_PRODUCT_SHIFT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                C_REG_TOP_COUNT:     r_cfg.top_count     <= i_cfg_data[3:0];
                C_REG_DENSITY_COUNT: r_cfg.density_count <= i_cfg_data[8:0];
                C_REG_PRODUCT_SHIFT: r_cfg.product_shift <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    gts_front #(
        .MAX_TOP (MAX_TOP)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_obs_value    (i_obs_value),
        .i_mean_value   (i_mean_value),
        .i_precision    (i_precision),
        .i_log_norm     (i_log_norm),
        .i_density_id   (i_density_id),
        .i_first_dim    (i_first_dim),
        .i_last_dim     (i_last_dim),
        .i_last_density (i_last_density),
        .i_q_full       (q_full),
        .o_ev_push      (ev_push),
        .o_ev           (push_ev)
    );

    gts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (ev_push),
        .i_ev    (push_ev),
        .o_full  (q_full),
        .o_empty (q_empty),
        .i_pop   (ev_pop),
        .o_head  (head_ev)
    );

    gts_back #(
        .MAX_TOP (MAX_TOP)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_ev          (head_ev),
        .o_pop         (ev_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_score       (score_bits),
        .o_best_id     (o_best_id),
        .o_last_result (o_last_result)
    );

    assign o_score = signed'(score_bits);

endmodule

FILE: src/gts_checker.sv
module gts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_stall,
    input logic        i_out_valid,
    input logic        i_out_stall,
    input logic [31:0] i_score,
    input logic [7:0]  i_best_id,
    input logic        i_last_result
);

    // Reset leaves no result pending and the queue empty.
    a_reset_out_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_reset_in_open: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_stall)
        else $error("input stalled right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=>
            $stable(i_score) && $stable(i_best_id) && $stable(i_last_result))
        else $error("result changed while stalled");

endmodule

bind gaussian_topn_scorer gts_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_stall    (o_in_stall),
    .i_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .i_score       (o_score),
    .i_best_id     (o_best_id),
    .i_last_result (o_last_result)
);
